>>> design/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
// Used by the front, queue, back and top-level modules; no dependencies.
package tcgr_pkg;

  localparam int CELL_WIDTH    = 8;
  localparam int CELL_HEIGHT   = 16;
  localparam int GLYPH_COUNT   = 256;
  localparam int WRAP_MARGIN   = 20;
  localparam int SCROLL_MARGIN = 40;
  localparam int TAB_CELLS     = 4;

  localparam int POS_W     = 13;
  localparam int OUT_W     = 12;
  localparam int COLOR_W   = 24;
  localparam int CODE_W    = 8;
  localparam int GROW_W    = 4;
  localparam int BITS_W    = 8;
  localparam int FONT_AW   = CODE_W + GROW_W;
  localparam int ROW_CNT_W = $clog2(CELL_HEIGHT);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COLOR_W-1:0] INK_RESET   = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] PAPER_RESET = 24'h000000;
  localparam logic [POS_W-1:0]   WIDTH_RESET  = 13'd1024;
  localparam logic [POS_W-1:0]   HEIGHT_RESET = 13'd768;

  typedef enum logic [2:0] {
    OP_GLYPH     = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_TAB       = 3'd2,
    OP_BACKSPACE = 3'd3,
    OP_LOAD      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_INK    = 2'd2,
    REG_PAPER  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCROLL,
    BK_ROWS
  } back_state_t;

  typedef enum logic {
    KIND_ROW    = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0]   width;
    logic [POS_W-1:0]   height;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;
  } cfg_t;

  // One unit of work for the back part.
  typedef struct packed {
    logic              load;     // font row write, no results
    logic              scroll;   // emit a scroll first
    logic              rows;     // emit a cell of rows
    logic              erase;    // rows are paper fill
    logic              glyph_ok; // code lies within the font
    logic [OUT_W-1:0]  band;
    logic [OUT_W-1:0]  x;
    logic [OUT_W-1:0]  y;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] grow;
    logic [BITS_W-1:0] bits;
  } job_t;

endpackage

>>> design/text_console_glyph_renderer.sv
// Text console glyph renderer: a glyph draw gives 16 row commands, 17 with a
// scroll; results leave one result a cycle while m_tready is high, and a font
// load gives no result. A 4-entry job queue lets commands arrive while results
// drain. Reset clears the cursor and queue and loads the register reset values;
// the font store is not cleared and must be loaded before use.
module text_console_glyph_renderer
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], glyph_row[11:8], row_bits[19:12]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12], pixel_mask[31:24],
                                 // paint_color[55:32]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     push, pop, q_full, q_empty;
  job_t     push_job, head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
      cfg.ink    <= INK_RESET;
      cfg.paper  <= PAPER_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_WIDTH:  cfg.width  <= pwdata[POS_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[POS_W-1:0];
        REG_INK:    cfg.ink    <= pwdata[COLOR_W-1:0];
        REG_PAPER:  cfg.paper  <= pwdata[COLOR_W-1:0];
        default:    cfg.width  <= cfg.width;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      REG_INK:    prdata = 32'(cfg.ink);
      REG_PAPER:  prdata = 32'(cfg.paper);
      default:    prdata = '0;
    endcase
  end

  tcgr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  tcgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tcgr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // a run of results never pauses once started
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == KIND_ROW)
    else $error("result run broken before its last item");

  // rows of one cell step down one pixel row at the same column
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tuser == KIND_ROW |=>
      m_tdata[23:12] == $past(m_tdata[23:12]) + 12'd1 &&
      m_tdata[11:0] == $past(m_tdata[11:0]))
    else $error("cell rows out of sequence");

  // a scroll carries no column and no mask
  a_scroll_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SCROLL |-> m_tdata[11:0] == 12'd0 && m_tdata[31:24] == 8'd0)
    else $error("scroll item with column or mask set");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty) && !(pop && q_empty))
    else $error("job queue flags inconsistent");
`endif

endmodule

>>> design/tcgr_front.sv
// Front part: accepts console commands, moves the cursor and turns each
// command that has work for the back part into a job. Depends on tcgr_pkg.
module tcgr_front
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], glyph_row[11:8], row_bits[19:12]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  localparam logic [POS_W:0] WRAP_ADD   = (POS_W+1)'(WRAP_MARGIN);
  localparam logic [POS_W:0] SCROLL_ADD = (POS_W+1)'(SCROLL_MARGIN);
  localparam logic [POS_W-1:0] CW  = POS_W'(CELL_WIDTH);
  localparam logic [POS_W-1:0] CH  = POS_W'(CELL_HEIGHT);
  localparam logic [POS_W-1:0] TAB = POS_W'(CELL_WIDTH * TAB_CELLS);

  logic [POS_W-1:0] cursor_x, cursor_x_next;
  logic [POS_W-1:0] cursor_y, cursor_y_next;

  logic [CODE_W-1:0] code;
  logic              accept;
  logic              has_job;
  logic [POS_W-1:0]  tab_x, nl_y, ysel, ys, y_up, x_back, x_prev;
  logic              wrap_draw, wrap_tab, scroll_hit, scroll_req;
  logic [POS_W-1:0]  band_full;
  op_t               op;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && has_job;
  assign code     = s_tdata[7:0];
  assign op       = op_t'(s_tuser);

  always_comb begin
    tab_x     = cursor_x + TAB;
    nl_y      = cursor_y + CH;
    wrap_draw = ({1'b0, cursor_x} + WRAP_ADD) >= {1'b0, cfg.width};
    wrap_tab  = ({1'b0, tab_x} + WRAP_ADD) >= {1'b0, cfg.width};
    // draw without wrap checks the current line, all other cases the next
    ysel       = (op == OP_GLYPH && !wrap_draw) ? cursor_y : nl_y;
    scroll_hit = ({1'b0, ysel} + SCROLL_ADD) >= {1'b0, cfg.height};
    ys         = (ysel >= CH) ? ysel - CH : '0;
    band_full  = (cfg.height >= CH) ? cfg.height - CH : '0;
    y_up       = cursor_y - CH;
    x_back     = (cfg.width >= CW) ? cfg.width - CW : '0;
    x_prev     = (cursor_x >= CW) ? cursor_x - CW : '0;

    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    has_job       = 1'b0;
    scroll_req    = 1'b0;

    job          = '0;
    job.band     = band_full[OUT_W-1:0];
    job.code     = code;
    job.grow     = s_tdata[11:8];
    job.bits     = s_tdata[19:12];
    job.glyph_ok = ({1'b0, code} < (CODE_W+1)'(GLYPH_COUNT));

    case (op)
      OP_GLYPH: begin
        scroll_req    = scroll_hit;
        has_job       = 1'b1;
        job.scroll    = scroll_hit;
        job.rows      = 1'b1;
        job.x         = wrap_draw ? '0 : cursor_x[OUT_W-1:0];
        cursor_y_next = scroll_hit ? ys : ysel;
        cursor_x_next = (wrap_draw ? '0 : cursor_x) + CW;
        job.y         = cursor_y_next[OUT_W-1:0];
      end
      OP_NEWLINE: begin
        scroll_req    = scroll_hit;
        has_job       = scroll_hit;
        job.scroll    = scroll_hit;
        cursor_x_next = '0;
        cursor_y_next = scroll_hit ? ys : nl_y;
      end
      OP_TAB: begin
        if (wrap_tab) begin
          scroll_req    = scroll_hit;
          has_job       = scroll_hit;
          job.scroll    = scroll_hit;
          cursor_x_next = '0;
          cursor_y_next = scroll_hit ? ys : nl_y;
        end else begin
          cursor_x_next = tab_x;
        end
      end
      OP_BACKSPACE: begin
        if (cursor_x == '0) begin
          if (cursor_y >= CH) begin
            has_job       = 1'b1;
            cursor_y_next = y_up;
            cursor_x_next = x_back;
          end
        end else begin
          has_job       = 1'b1;
          cursor_x_next = x_prev;
        end
        job.rows  = 1'b1;
        job.erase = 1'b1;
        job.x     = cursor_x_next[OUT_W-1:0];
        job.y     = cursor_y_next[OUT_W-1:0];
      end
      OP_LOAD: begin
        has_job  = 1'b1;
        job.load = 1'b1;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
    job.scroll = job.scroll && scroll_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

endmodule

>>> design/tcgr_queue.sv
// Short job queue between the front and back parts.
// Depends on tcgr_pkg for the job type and depth.
module tcgr_queue
  import tcgr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/tcgr_back.sv
// Back part (depends on tcgr_pkg): takes jobs from the queue, owns the font store and
// emits one paint or scroll command per unstalled cycle through an output register.
module tcgr_back
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12], pixel_mask[31:24],
                                 // paint_color[55:32]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast
);

  localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(CELL_HEIGHT - 1);

  back_state_t          state, state_next;
  job_t                 job, job_next;
  logic [ROW_CNT_W-1:0] row, row_next;

  logic [BITS_W-1:0] font [2**FONT_AW];
  logic [BITS_W-1:0] rd_q;

  logic               adv, done, emit;
  kind_t              e_kind;
  logic [OUT_W-1:0]   e_x, e_y;
  logic [BITS_W-1:0]  e_mask;
  logic [COLOR_W-1:0] e_color;
  logic               e_last, e_font;

  logic               out_valid;
  kind_t              out_kind;
  logic [OUT_W-1:0]   out_x, out_y;
  logic [BITS_W-1:0]  out_mask;
  logic [COLOR_W-1:0] out_color;
  logic               out_last, out_font;

  assign adv = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    row <= row_next;
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    row_next   = row;
    pop        = 1'b0;
    done       = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_ROW;
    e_x        = job.x;
    e_y        = job.y + OUT_W'(row);
    e_mask     = job.erase ? '1 : '0;
    e_color    = job.erase ? cfg.paper : cfg.ink;
    e_last     = 1'b0;
    e_font     = !job.erase && job.glyph_ok;
    case (state)
      BK_IDLE: begin
        done = 1'b1;
      end
      BK_SCROLL: begin
        e_kind  = KIND_SCROLL;
        e_x     = '0;
        e_y     = job.band;
        e_mask  = '0;
        e_color = cfg.paper;
        e_font  = 1'b0;
        e_last  = !job.rows;
        if (adv) begin
          emit     = 1'b1;
          row_next = '0;
          if (job.rows) begin
            state_next = BK_ROWS;
          end else begin
            done = 1'b1;
          end
        end
      end
      BK_ROWS: begin
        e_last = (row == LAST_ROW);
        if (adv) begin
          emit     = 1'b1;
          row_next = row + 1'b1;
          done     = e_last;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    // take the next job in the cycle the current one finishes
    if (done) begin
      state_next = BK_IDLE;
      if (!q_empty) begin
        pop = 1'b1;
        if (!head.load) begin
          job_next   = head;
          row_next   = '0;
          state_next = head.scroll ? BK_SCROLL : BK_ROWS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.load && head.glyph_ok) begin
      font[{head.code, head.grow}] <= head.bits;
    end
    if (emit && e_font) begin
      rd_q <= font[{job.code, GROW_W'(row)}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= e_kind;
      out_x     <= e_x;
      out_y     <= e_y;
      out_mask  <= e_mask;
      out_color <= e_color;
      out_last  <= e_last;
      out_font  <= e_font;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_color, (out_font ? rd_q : out_mask), out_y, out_x};

endmodule

>>> tb/text_console_glyph_renderer_check.sv
`timescale 1ns / 1ps
// Checker for the text console glyph renderer: snoops the register port and both streams,
// keeps its own cursor, font and register copies, and compares every paint item.
// Depends on tcgr_pkg for the register, opcode and result kind codes.
module text_console_glyph_renderer_check
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], glyph_row[11:8], row_bits[19:12]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12], pixel_mask[31:24],
                                 // paint_color[55:32]
  input  logic        m_tuser,   // kind[0]
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    kind_t              kind;
    logic [OUT_W-1:0]   x;
    logic [OUT_W-1:0]   y;
    logic [7:0]         mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } paint_t;

  cfg_t              screen;
  logic [POS_W-1:0]  cur_x;
  logic [POS_W-1:0]  cur_y;
  logic [BITS_W-1:0] font_rows [1 << FONT_AW];
  paint_t            expected_paint [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic queue_paint(kind_t kind, logic [31:0] x, logic [31:0] y, logic [7:0] mask,
                             logic [COLOR_W-1:0] color);
    paint_t p;
    p.kind  = kind;
    p.x     = x[OUT_W-1:0];
    p.y     = y[OUT_W-1:0];
    p.mask  = mask;
    p.color = color;
    p.last  = 1'b0;
    expected_paint.push_back(p);
  endtask

  task automatic advance_line();
    cur_x = '0;
    cur_y = cur_y + POS_W'(CELL_HEIGHT);
  endtask

  // Scroll up one cell row when the cursor is too close to the bottom.
  task automatic scroll_if_low();
    logic [31:0] band;
    if (cur_y + SCROLL_MARGIN >= screen.height) begin
      band = (screen.height >= CELL_HEIGHT) ? screen.height - CELL_HEIGHT : 32'd0;
      queue_paint(KIND_SCROLL, 32'd0, band, 8'h00, screen.paper);
      cur_y = (cur_y >= CELL_HEIGHT) ? cur_y - POS_W'(CELL_HEIGHT) : '0;
    end
  endtask

  task automatic predict_command(logic [2:0] op, logic [CODE_W-1:0] code,
                                 logic [GROW_W-1:0] grow, logic [BITS_W-1:0] bits);
    int     prior_size;
    paint_t tail;
    prior_size = expected_paint.size();
    case (op)
      OP_GLYPH: begin
        if (cur_x + WRAP_MARGIN >= screen.width) advance_line();
        scroll_if_low();
        for (int r = 0; r < CELL_HEIGHT; r++) begin
          queue_paint(KIND_ROW, 32'(cur_x), 32'(cur_y) + 32'(r), font_rows[{code, 4'(r)}],
                      screen.ink);
        end
        cur_x = cur_x + POS_W'(CELL_WIDTH);
      end
      OP_NEWLINE: begin
        advance_line();
        scroll_if_low();
      end
      OP_TAB: begin
        cur_x = cur_x + POS_W'(CELL_WIDTH * TAB_CELLS);
        if (cur_x + WRAP_MARGIN >= screen.width) begin
          advance_line();
          scroll_if_low();
        end
      end
      OP_BACKSPACE: begin
        // nothing to erase at the top-left cell
        if (cur_x != 0 || cur_y >= CELL_HEIGHT) begin
          if (cur_x == 0) begin
            cur_y = cur_y - POS_W'(CELL_HEIGHT);
            cur_x = (screen.width >= CELL_WIDTH) ? screen.width - POS_W'(CELL_WIDTH) : '0;
          end else begin
            cur_x = (cur_x >= CELL_WIDTH) ? cur_x - POS_W'(CELL_WIDTH) : '0;
          end
          for (int r = 0; r < CELL_HEIGHT; r++) begin
            queue_paint(KIND_ROW, 32'(cur_x), 32'(cur_y) + 32'(r), 8'hFF, screen.paper);
          end
        end
      end
      OP_LOAD: font_rows[{code, grow}] = bits;
      default: ;
    endcase
    // flag the final item of this command
    if (expected_paint.size() > prior_size) begin
      tail = expected_paint.pop_back();
      tail.last = 1'b1;
      expected_paint.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    paint_t      want;
    logic [31:0] reg_now;
    if (rst) begin
      screen.width  = WIDTH_RESET;
      screen.height = HEIGHT_RESET;
      screen.ink    = INK_RESET;
      screen.paper  = PAPER_RESET;
      cur_x = '0;
      cur_y = '0;
      expected_paint.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  screen.width  = pwdata[POS_W-1:0];
            REG_HEIGHT: screen.height = pwdata[POS_W-1:0];
            REG_INK:    screen.ink    = pwdata[COLOR_W-1:0];
            REG_PAPER:  screen.paper  = pwdata[COLOR_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  reg_now = 32'(screen.width);
            REG_HEIGHT: reg_now = 32'(screen.height);
            REG_INK:    reg_now = 32'(screen.ink);
            default:    reg_now = 32'(screen.paper);
          endcase
          if (prdata !== reg_now) report_mismatch("register read", prdata, reg_now);
        end
      end

      if (m_tvalid && m_tready) begin
        if (expected_paint.size() == 0) begin
          report_mismatch("item with nothing expected", m_tdata[31:0], 32'd0);
        end else begin
          want = expected_paint.pop_front();
          if (m_tuser !== want.kind) begin
            report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
          end
          if (m_tdata[11:0] !== want.x) begin
            report_mismatch("pixel_x", 32'(m_tdata[11:0]), 32'(want.x));
          end
          if (m_tdata[23:12] !== want.y) begin
            report_mismatch("pixel_y", 32'(m_tdata[23:12]), 32'(want.y));
          end
          if (m_tdata[31:24] !== want.mask) begin
            report_mismatch("pixel_mask", 32'(m_tdata[31:24]), 32'(want.mask));
          end
          if (m_tdata[55:32] !== want.color) begin
            report_mismatch("paint_color", 32'(m_tdata[55:32]), 32'(want.color));
          end
          if (m_tlast !== want.last) begin
            report_mismatch("last", 32'(m_tlast), 32'(want.last));
          end
        end
      end

      if (s_tvalid && s_tready) begin
        predict_command(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[19:12]);
      end
    end
    pending <= expected_paint.size();
  end

endmodule

>>> tb/text_console_glyph_renderer_test.sv
`timescale 1ns / 1ps
// Top of the text console glyph renderer testbench: clock, reset, register writes and
// command stimulus under several idling phases; checking lives in the checker module.
// Depends on tcgr_pkg, the renderer and text_console_glyph_renderer_check.
module text_console_glyph_renderer_test;
  import tcgr_pkg::*;

  localparam int RUN_LIMIT    = 500_000;
  localparam int QUIET_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 31;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  bit [15:0]  rows_loaded [256];
  bit         glyph_ready [256];
  logic [7:0] ready_glyphs [$];

  text_console_glyph_renderer u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  text_console_glyph_renderer_check u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one command item and hold it until taken; valid stays high between
  // back-to-back items.
  task automatic send_cmd(logic [2:0] op, logic [7:0] code, logic [3:0] grow,
                          logic [7:0] bits);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, bits, grow, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] op);
    send_cmd(op, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic send_glyph(logic [7:0] code);
    send_cmd(OP_GLYPH, code, 4'($urandom), 8'($urandom));
  endtask

  task automatic load_row(logic [7:0] code, logic [3:0] row, logic [7:0] bits);
    send_cmd(OP_LOAD, code, row, bits);
    rows_loaded[code][row] = 1'b1;
    if (rows_loaded[code] == 16'hFFFF && !glyph_ready[code]) begin
      glyph_ready[code] = 1'b1;
      ready_glyphs.push_back(code);
    end
  endtask

  task automatic load_glyph(logic [7:0] code);
    for (int r = 0; r < CELL_HEIGHT; r++) begin
      load_row(code, 4'(r), (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom));
    end
  endtask

  // Hold off the sender until every paint item has come, then let the block settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_screen(int w, int h, logic [23:0] ink, logic [23:0] paper);
    wait_drained();
    apb_access(1'b1, REG_WIDTH, 32'(w));
    apb_access(1'b1, REG_HEIGHT, 32'(h));
    apb_access(1'b1, REG_INK, 32'(ink));
    apb_access(1'b1, REG_PAPER, 32'(paper));
    apb_access(1'b0, REG_WIDTH, 32'd0);
    apb_access(1'b0, REG_HEIGHT, 32'd0);
    apb_access(1'b0, REG_INK, 32'd0);
    apb_access(1'b0, REG_PAPER, 32'd0);
  endtask

  initial begin
    int          n;
    int          pick;
    int          burst;
    int          w;
    int          h;
    logic [23:0] ink;
    logic [23:0] paper;
    bit          paused;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fonts first: nothing may draw a row that was never loaded
    load_glyph(8'h00);
    load_glyph(8'hFF);
    load_glyph(8'hA5);

    // reset screen: top-left backspace, ignored opcodes, glyphs, tab, newline and backspace
    send_op(OP_BACKSPACE);
    for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++) send_op(3'(op));
    send_glyph(8'h00);
    send_glyph(8'hFF);
    send_glyph(8'hA5);
    send_op(OP_TAB);
    send_op(OP_BACKSPACE);
    send_op(OP_NEWLINE);
    send_op(OP_BACKSPACE);
    send_glyph(8'hFF);

    // narrow screen: line-start and partial-cell backspace, scrolls
    set_screen(12, 64, 24'h000000, 24'hFFFFFF);
    idle_pct = 34;
    stall_pct <= 34;
    send_op(OP_NEWLINE);
    send_op(OP_BACKSPACE);
    send_op(OP_BACKSPACE);
    send_op(OP_NEWLINE);
    send_op(OP_NEWLINE);
    send_op(OP_TAB);
    send_glyph(8'hA5);

    for (int ph = 0; ph < PHASES; ph++) begin
      ink   = 24'($urandom);
      paper = 24'($urandom);
      w     = $urandom_range(64, 300) | 1;
      h     = $urandom_range(64, 300);
      case (ph)
        0: begin w = 1024; h = 768; ink = INK_RESET; paper = PAPER_RESET; end
        1: begin w = 64; h = 64; ink = 24'h000000; paper = 24'hFFFFFF; end
        2: begin w = 4096; h = 4096; end
        3: begin w = 8191; h = 100; end   // cursor runs past the 12-bit outputs
        4: begin w = 4096; h = 30; end    // scroll from the top row
        5: begin w = 7; h = 4096; end     // line start below one cell width
        6: begin w = 6; h = 14; end       // bottom band below one cell height
        default: ;
      endcase
      set_screen(w, h, ink, paper);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 87; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 87; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase

      send_op(OP_NEWLINE);
      send_op(OP_BACKSPACE);
      n = 2;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        if (!paused && n >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_glyph(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
          n++;
        end else if (pick < 55) begin
          send_op(OP_NEWLINE);
          n++;
        end else if (pick < 65) begin
          send_op(OP_TAB);
          n++;
        end else if (pick < 78) begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_op(OP_BACKSPACE);
          n += burst;
        end else if (pick < 82) begin
          load_glyph(8'($urandom));
          n += CELL_HEIGHT;
        end else if (pick < 95) begin
          load_row(8'($urandom), 4'($urandom), 8'($urandom));
          n++;
        end else begin
          // ignored items do not advance the count
          send_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tcgr_pkg.sv
design/tcgr_front.sv
design/tcgr_queue.sv
design/tcgr_back.sv
design/text_console_glyph_renderer.sv
tb/text_console_glyph_renderer_check.sv
tb/text_console_glyph_renderer_test.sv
